### rtl/i2c_bitbang_master_engine_top_defines.svh
// Assertion macros for the RTL of the I2C bit-bang master engine.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef I2C_BITBANG_MASTER_ENGINE_TOP_DEFINES_SVH
`define I2C_BITBANG_MASTER_ENGINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define I2CBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define I2CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CBB_ASSERT_NOW(lbl, ante, cons, msg)
`define I2CBB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/i2cbb_pkg.sv
`timescale 1ns / 1ps

package i2cbb_pkg;

  // Opcodes on the input beat
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_SEND     = 3'd3;
  localparam logic [2:0] OP_RECV     = 3'd4;
  localparam logic [2:0] OP_SEND_ACK = 3'd5;
  localparam logic [2:0] OP_RECV_ACK = 3'd6;

  // Steps per command
  localparam logic [4:0] LEN_START    = 5'd4;
  localparam logic [4:0] LEN_STOP     = 5'd3;
  localparam logic [4:0] LEN_SEND     = 5'd24;
  localparam logic [4:0] LEN_RECV     = 5'd25;
  localparam logic [4:0] LEN_SEND_ACK = 5'd3;
  localparam logic [4:0] LEN_RECV_ACK = 5'd4;

  // Last phase of a bit slot (send: SDA, SCL high, SCL low; receive: SCL high, read, SCL low)
  localparam logic [1:0] PHASE_LAST = 2'd2;

  localparam logic [15:0] STEP_TICKS_RESET = 16'd1;

  // Command being sequenced
  typedef enum logic [2:0] {
    CMD_IDLE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_SEND     = 3'd3,
    CMD_RECV     = 3'd4,
    CMD_SEND_ACK = 3'd5,
    CMD_RECV_ACK = 3'd6
  } cmd_state_t;

  // Pin action of one step
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SDA  = 2'd1,
    ACT_SCL  = 2'd2,
    ACT_READ = 2'd3
  } act_kind_t;

  typedef struct packed {
    act_kind_t  kind;
    logic       val;
    logic [2:0] bit_pos;
  } step_act_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       cmd_rejected;
  } out_item_t;

  // Map an opcode onto the command it launches; unused codes launch nothing
  function automatic cmd_state_t op_to_cmd(logic [2:0] op);
    cmd_state_t c;
    c = CMD_IDLE;
    unique case (op)
      OP_START:    c = CMD_START;
      OP_STOP:     c = CMD_STOP;
      OP_SEND:     c = CMD_SEND;
      OP_RECV:     c = CMD_RECV;
      OP_SEND_ACK: c = CMD_SEND_ACK;
      OP_RECV_ACK: c = CMD_RECV_ACK;
      default:     c = CMD_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] cmd_length(cmd_state_t c);
    logic [4:0] n;
    n = 5'd0;
    unique case (c)
      CMD_START:    n = LEN_START;
      CMD_STOP:     n = LEN_STOP;
      CMD_SEND:     n = LEN_SEND;
      CMD_RECV:     n = LEN_RECV;
      CMD_SEND_ACK: n = LEN_SEND_ACK;
      CMD_RECV_ACK: n = LEN_RECV_ACK;
      default:      n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/i2c_bitbang_master_engine_top.sv
`timescale 1ns / 1ps

// Channel  Ports                            Beat
// -------  -------------------------------  ---------------------------------
// input    in_valid / in_ready / in_data    one timing tick: opcode, bytes, SDA
// result   out_valid / out_ready / out_data pin levels and status after tick
// config   cfg_we / cfg_wdata               step_ticks, taken on any cfg_we
//
// One tick is taken per cycle while no result is stalled; its result appears
// in the output register on the next cycle. The sequencer state and the
// single output register set this behaviour.
// Reset is synchronous on rst_n: SCL and SDA released, sequencer idle.
// A stalled result holds the output register and drops in_ready; no tick is
// taken until the result leaves.

module i2c_bitbang_master_engine_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cbb_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cbb_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);

  i2cbb_pkg::out_item_t res;
  logic                 accept;

  // Advance the sequencer on each accepted beat
  assign accept = in_valid && in_ready;

  i2cbb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  i2cbb_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/i2cbb_step_dec.sv
`timescale 1ns / 1ps

module i2cbb_step_dec (
  input  i2cbb_pkg::cmd_state_t cmd,
  input  logic [4:0]            step_idx,
  input  logic [1:0]            phase,
  input  logic [2:0]            bit_idx,
  input  logic [7:0]            shift_byte,
  output i2cbb_pkg::step_act_t  act
);

  logic [2:0] bit_pos;

  // MSB goes first
  assign bit_pos = 3'd7 - bit_idx;

  // Decode the pin action of the current step
  always_comb begin
    act.kind    = i2cbb_pkg::ACT_NONE;
    act.val     = 1'b1;
    act.bit_pos = bit_pos;
    unique case (cmd)
      i2cbb_pkg::CMD_START: begin
        act.kind = step_idx[0] ? i2cbb_pkg::ACT_SCL : i2cbb_pkg::ACT_SDA;
        act.val  = (step_idx < 5'd2);
      end
      i2cbb_pkg::CMD_STOP: begin
        act.kind = (step_idx == 5'd1) ? i2cbb_pkg::ACT_SCL : i2cbb_pkg::ACT_SDA;
        act.val  = (step_idx != 5'd0);
      end
      i2cbb_pkg::CMD_SEND: begin
        if (phase == 2'd0) begin
          act.kind = i2cbb_pkg::ACT_SDA;
          act.val  = shift_byte[bit_pos];
        end else begin
          act.kind = i2cbb_pkg::ACT_SCL;
          act.val  = (phase == 2'd1);
        end
      end
      i2cbb_pkg::CMD_RECV: begin
        // Release SDA first, then clock in eight bits
        if (step_idx == 5'd0) begin
          act.kind = i2cbb_pkg::ACT_SDA;
          act.val  = 1'b1;
        end else if (phase == 2'd1) begin
          act.kind = i2cbb_pkg::ACT_READ;
        end else begin
          act.kind = i2cbb_pkg::ACT_SCL;
          act.val  = (phase == 2'd0);
        end
      end
      i2cbb_pkg::CMD_SEND_ACK: begin
        if (step_idx == 5'd0) begin
          act.kind = i2cbb_pkg::ACT_SDA;
          act.val  = shift_byte[0];
        end else begin
          act.kind = i2cbb_pkg::ACT_SCL;
          act.val  = (step_idx == 5'd1);
        end
      end
      i2cbb_pkg::CMD_RECV_ACK: begin
        if (step_idx == 5'd2) begin
          act.kind = i2cbb_pkg::ACT_READ;
        end else begin
          act.kind = (step_idx == 5'd0) ? i2cbb_pkg::ACT_SDA : i2cbb_pkg::ACT_SCL;
          act.val  = (step_idx != 5'd3);
        end
      end
      default: begin
        act.kind = i2cbb_pkg::ACT_NONE;
      end
    endcase
  end

endmodule

### rtl/i2cbb_core.sv
`timescale 1ns / 1ps

`include "i2c_bitbang_master_engine_top_defines.svh"

module i2cbb_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  i2cbb_pkg::in_item_t  in_item,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  output i2cbb_pkg::out_item_t res
);

  // Sequencer state
  i2cbb_pkg::cmd_state_t cmd_r, cmd_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_r, ack_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic [15:0] step_ticks_r;

  // Values seen by this beat once a new command is latched
  i2cbb_pkg::cmd_state_t start_cmd, eff_cmd;
  logic        starting;
  logic [4:0]  eff_idx;
  logic [15:0] eff_tick;
  logic [1:0]  eff_phase;
  logic [2:0]  eff_bit;
  logic [7:0]  eff_shift;

  logic [15:0] hold;
  logic [15:0] tick_inc;
  logic [4:0]  idx_inc;
  logic        busy;
  logic        cmd_last;
  logic        rejected;

  i2cbb_pkg::step_act_t act;

  // Zero step length counts as one tick
  assign hold = (step_ticks_r == 16'd0) ? 16'd1 : step_ticks_r;

  // Latch a new command only when idle
  always_comb begin
    start_cmd = i2cbb_pkg::op_to_cmd(in_item.opcode);
    starting  = (cmd_r == i2cbb_pkg::CMD_IDLE) && (start_cmd != i2cbb_pkg::CMD_IDLE);
    rejected  = (cmd_r != i2cbb_pkg::CMD_IDLE) && (in_item.opcode != i2cbb_pkg::OP_NONE);
    eff_cmd   = starting ? start_cmd : cmd_r;
    eff_idx   = starting ? 5'd0  : idx_r;
    eff_tick  = starting ? 16'd0 : tick_r;
    eff_phase = starting ? 2'd0  : phase_r;
    eff_bit   = starting ? 3'd0  : bit_r;
    eff_shift = shift_r;
    if (starting) begin
      priority case (start_cmd)
        i2cbb_pkg::CMD_SEND:     eff_shift = in_item.tx_byte;
        i2cbb_pkg::CMD_RECV:     eff_shift = 8'd0;
        i2cbb_pkg::CMD_SEND_ACK: eff_shift = {7'd0, in_item.ack_level};
        default:                 eff_shift = shift_r;
      endcase
    end
  end

  i2cbb_step_dec u_step_dec (
    .cmd        (eff_cmd),
    .step_idx   (eff_idx),
    .phase      (eff_phase),
    .bit_idx    (eff_bit),
    .shift_byte (eff_shift),
    .act        (act)
  );

  // Next command state: drop back to idle after the last step
  always_comb begin
    cmd_nxt = cmd_last ? i2cbb_pkg::CMD_IDLE : eff_cmd;
  end

  // Pin actions, tick and step counting, result
  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    shift_nxt = eff_shift;
    tick_nxt  = eff_tick;
    idx_nxt   = eff_idx;
    phase_nxt = eff_phase;
    bit_nxt   = eff_bit;
    tick_inc  = eff_tick + 16'd1;
    idx_inc   = eff_idx + 5'd1;
    busy      = (eff_cmd != i2cbb_pkg::CMD_IDLE);
    cmd_last  = 1'b0;

    if (busy) begin
      // Act on the first tick of a step
      if (eff_tick == 16'd0) begin
        unique case (act.kind)
          i2cbb_pkg::ACT_SDA: sda_nxt = act.val;
          i2cbb_pkg::ACT_SCL: scl_nxt = act.val;
          i2cbb_pkg::ACT_READ: begin
            if (eff_cmd == i2cbb_pkg::CMD_RECV) begin
              if (in_item.sda_in) begin
                shift_nxt[act.bit_pos] = 1'b1;
              end
            end else begin
              ack_nxt = in_item.sda_in;
            end
          end
          i2cbb_pkg::ACT_NONE: ;
          default: ;
        endcase
      end

      if (tick_inc >= hold) begin
        tick_nxt = 16'd0;
        // Advance the bit slot; the SDA release step of receive sits outside it
        if (!((eff_cmd == i2cbb_pkg::CMD_RECV) && (eff_idx == 5'd0))) begin
          if (eff_phase == i2cbb_pkg::PHASE_LAST) begin
            phase_nxt = 2'd0;
            bit_nxt   = eff_bit + 3'd1;
          end else begin
            phase_nxt = eff_phase + 2'd1;
          end
        end
        if (idx_inc >= i2cbb_pkg::cmd_length(eff_cmd)) begin
          cmd_last  = 1'b1;
          idx_nxt   = 5'd0;
          phase_nxt = 2'd0;
          bit_nxt   = 3'd0;
          if (eff_cmd == i2cbb_pkg::CMD_RECV) begin
            rx_nxt = shift_nxt;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end

    res.scl_out      = scl_nxt;
    res.sda_out      = sda_nxt;
    res.busy_res     = busy;
    res.done_res     = cmd_last;
    res.rx_byte      = rx_nxt;
    res.ack_seen     = ack_nxt;
    res.cmd_rejected = rejected;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= i2cbb_pkg::CMD_IDLE;
      idx_r   <= 5'd0;
      tick_r  <= 16'd0;
      phase_r <= 2'd0;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b1;
      rx_r    <= 8'd0;
    end else if (accept) begin
      cmd_r   <= cmd_nxt;
      idx_r   <= idx_nxt;
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
    end
  end

  // Step length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r <= i2cbb_pkg::STEP_TICKS_RESET;
    end else if (cfg_we) begin
      step_ticks_r <= cfg_wdata;
    end
  end

  `I2CBB_ASSERT_NOW(a_idle_counters_clear, cmd_r == i2cbb_pkg::CMD_IDLE, (idx_r == 5'd0) && (tick_r == 16'd0), "idle with step or tick count left over")
  `I2CBB_ASSERT_NOW(a_step_in_range, cmd_r != i2cbb_pkg::CMD_IDLE, idx_r < i2cbb_pkg::cmd_length(cmd_r), "step index past command length")
  `I2CBB_ASSERT_NOW(a_phase_in_range, cmd_r != i2cbb_pkg::CMD_IDLE, phase_r != 2'd3, "bit slot phase out of range")
  `I2CBB_ASSERT_NEXT(a_done_goes_idle, accept && res.done_res, cmd_r == i2cbb_pkg::CMD_IDLE, "command still active after done")

endmodule

### rtl/i2cbb_out_reg.sv
`timescale 1ns / 1ps

module i2cbb_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cbb_pkg::out_item_t res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cbb_pkg::out_item_t out_data
);

  logic                 out_valid_r;
  i2cbb_pkg::out_item_t out_data_r;
  logic                 load;

  // Take a new beat whenever the held result is gone or leaves now
  assign in_ready = !out_valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] OP_UNUSED    = 3'd7;
  // Random traffic stops here so the whole run lands near 1350 beats
  localparam int         RANDOM_END   = 1200;
  localparam int         SDA_LOW      = 0;
  localparam int         SDA_HIGH     = 1;
  localparam int         SDA_RANDOM   = 2;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  i2cbb_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  i2cbb_pkg::out_item_t out_data;
  logic                 cfg_we    = 1'b0;
  logic [15:0]          cfg_wdata = '0;

  i2c_bitbang_master_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted sequencer state, at reset values
  logic [15:0]           p_len   = i2cbb_pkg::STEP_TICKS_RESET;
  i2cbb_pkg::cmd_state_t p_cmd   = i2cbb_pkg::CMD_IDLE;
  int unsigned           p_step  = 0;
  int unsigned           p_ticks = 0;
  logic [7:0]            p_shift = '0;
  logic [7:0]            p_rx    = '0;
  logic                  p_scl   = 1'b1;
  logic                  p_sda   = 1'b1;
  logic                  p_ack   = 1'b1;

  i2cbb_pkg::out_item_t pending_pins[$];
  i2cbb_pkg::out_item_t want;
  int        mismatches = 0;
  int        beats_sent = 0;
  int        burst_left = 0;
  logic [15:0] ready_word = '1;
  int        ready_pos  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned steps_of(i2cbb_pkg::cmd_state_t c);
    case (c)
      i2cbb_pkg::CMD_START:    return int'(i2cbb_pkg::LEN_START);
      i2cbb_pkg::CMD_STOP:     return int'(i2cbb_pkg::LEN_STOP);
      i2cbb_pkg::CMD_SEND:     return int'(i2cbb_pkg::LEN_SEND);
      i2cbb_pkg::CMD_RECV:     return int'(i2cbb_pkg::LEN_RECV);
      i2cbb_pkg::CMD_SEND_ACK: return int'(i2cbb_pkg::LEN_SEND_ACK);
      i2cbb_pkg::CMD_RECV_ACK: return int'(i2cbb_pkg::LEN_RECV_ACK);
      default:                 return 0;
    endcase
  endfunction

  // Perform the pin action of the current step
  function automatic void apply_pin_step(logic sda_in);
    i2cbb_pkg::act_kind_t kind;
    logic      val;
    int        bit_n;
    int        ph;
    int        i;
    kind  = i2cbb_pkg::ACT_NONE;
    val   = 1'b1;
    bit_n = 0;
    i     = p_step;
    case (p_cmd)
      i2cbb_pkg::CMD_START: begin
        kind = i[0] ? i2cbb_pkg::ACT_SCL : i2cbb_pkg::ACT_SDA;
        val  = (i < 2);
      end
      i2cbb_pkg::CMD_STOP: begin
        kind = (i == 1) ? i2cbb_pkg::ACT_SCL : i2cbb_pkg::ACT_SDA;
        val  = (i != 0);
      end
      i2cbb_pkg::CMD_SEND: begin
        bit_n = (i / 3) % 8;
        ph    = i % 3;
        kind  = (ph == 0) ? i2cbb_pkg::ACT_SDA : i2cbb_pkg::ACT_SCL;
        val   = (ph == 0) ? p_shift[7 - bit_n] : (ph == 1);
      end
      i2cbb_pkg::CMD_RECV: begin
        if (i == 0) begin
          kind = i2cbb_pkg::ACT_SDA;
        end else begin
          bit_n = ((i - 1) / 3) % 8;
          ph    = (i - 1) % 3;
          kind  = (ph == 1) ? i2cbb_pkg::ACT_READ : i2cbb_pkg::ACT_SCL;
          val   = (ph == 0);
        end
      end
      i2cbb_pkg::CMD_SEND_ACK: begin
        kind = (i == 0) ? i2cbb_pkg::ACT_SDA : i2cbb_pkg::ACT_SCL;
        val  = (i == 0) ? p_shift[0] : (i == 1);
      end
      i2cbb_pkg::CMD_RECV_ACK: begin
        if (i == 2) begin
          kind = i2cbb_pkg::ACT_READ;
        end else begin
          kind = (i == 0) ? i2cbb_pkg::ACT_SDA : i2cbb_pkg::ACT_SCL;
          val  = (i != 3);
        end
      end
      default: kind = i2cbb_pkg::ACT_NONE;
    endcase
    case (kind)
      i2cbb_pkg::ACT_SDA: p_sda = val;
      i2cbb_pkg::ACT_SCL: p_scl = val;
      i2cbb_pkg::ACT_READ: begin
        if (p_cmd == i2cbb_pkg::CMD_RECV) begin
          if (sda_in) p_shift[7 - bit_n] = 1'b1;
        end else begin
          p_ack = sda_in;
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the predicted sequencer by one tick and return its result beat
  function automatic i2cbb_pkg::out_item_t next_pin_state(i2cbb_pkg::in_item_t t);
    i2cbb_pkg::out_item_t r;
    int unsigned hold;
    logic        rej;
    logic        done;
    logic        busy;
    rej  = 1'b0;
    done = 1'b0;
    busy = 1'b0;
    hold = (p_len == 16'd0) ? 1 : int'(p_len);
    if (p_cmd != i2cbb_pkg::CMD_IDLE) begin
      if (t.opcode != i2cbb_pkg::OP_NONE) rej = 1'b1;
    end else if (t.opcode >= i2cbb_pkg::OP_START && t.opcode <= i2cbb_pkg::OP_RECV_ACK) begin
      p_cmd   = i2cbb_pkg::cmd_state_t'(t.opcode);
      p_step  = 0;
      p_ticks = 0;
      case (p_cmd)
        i2cbb_pkg::CMD_SEND:     p_shift = t.tx_byte;
        i2cbb_pkg::CMD_RECV:     p_shift = '0;
        i2cbb_pkg::CMD_SEND_ACK: p_shift = {7'd0, t.ack_level};
        default: ;
      endcase
    end
    if (p_cmd != i2cbb_pkg::CMD_IDLE) begin
      busy = 1'b1;
      if (p_ticks == 0) apply_pin_step(t.sda_in);
      p_ticks++;
      if (p_ticks >= hold) begin
        p_ticks = 0;
        p_step++;
        if (p_step >= steps_of(p_cmd)) begin
          done = 1'b1;
          if (p_cmd == i2cbb_pkg::CMD_RECV) p_rx = p_shift;
          p_cmd  = i2cbb_pkg::CMD_IDLE;
          p_step = 0;
        end
      end
    end
    r.scl_out      = p_scl;
    r.sda_out      = p_sda;
    r.busy_res     = busy;
    r.done_res     = done;
    r.rx_byte      = p_rx;
    r.ack_seen     = p_ack;
    r.cmd_rejected = rej;
    return r;
  endfunction

  // Receiver stalls follow a 16-bit ready pattern word, redrawn each time round
  always @(posedge clk) begin
    if (ready_pos == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_word = '1;
        1:       ready_word = 16'($urandom);
        default: ready_word = 16'($urandom & $urandom);
      endcase
    end
    out_ready <= ready_word[ready_pos];
    ready_pos = (ready_pos + 1) % 16;
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pins.size() == 0) begin
        $error("result beat with no prediction waiting");
        mismatches++;
      end else begin
        want = pending_pins.pop_front();
        check_field("scl_out",      8'(want.scl_out),      8'(out_data.scl_out));
        check_field("sda_out",      8'(want.sda_out),      8'(out_data.sda_out));
        check_field("busy_res",     8'(want.busy_res),     8'(out_data.busy_res));
        check_field("done_res",     8'(want.done_res),     8'(out_data.done_res));
        check_field("rx_byte",      want.rx_byte,          out_data.rx_byte);
        check_field("ack_seen",     8'(want.ack_seen),     8'(out_data.ack_seen));
        check_field("cmd_rejected", 8'(want.cmd_rejected), 8'(out_data.cmd_rejected));
      end
    end
  end

  function automatic i2cbb_pkg::in_item_t tick_item(logic [2:0] op, logic [7:0] tx,
                                                    logic ack, int sda_mode);
    i2cbb_pkg::in_item_t t;
    t.opcode    = op;
    t.tx_byte   = tx;
    t.ack_level = ack;
    t.sda_in    = (sda_mode == SDA_RANDOM) ? 1'($urandom) : (sda_mode == SDA_HIGH);
    return t;
  endfunction

  // Send one tick beat in bursts with random gaps; predict it once accepted
  task automatic send_tick(i2cbb_pkg::in_item_t t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_data  <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pins.push_back(next_pin_state(t));
    beats_sent++;
  endtask

  // Issue one command and tick until it completes; busy ticks may carry stray opcodes
  task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic ack, int sda_mode,
                         int noise_pct);
    logic [2:0] busy_op;
    send_tick(tick_item(op, tx, ack, sda_mode));
    while (p_cmd != i2cbb_pkg::CMD_IDLE) begin
      busy_op = ($urandom_range(1, 100) <= noise_pct) ? 3'($urandom_range(1, 7))
                                                      : i2cbb_pkg::OP_NONE;
      send_tick(tick_item(busy_op, 8'($urandom), 1'($urandom), sda_mode));
    end
  endtask

  // Bring the engine to idle, hold the sender and drain every result
  task automatic quiesce();
    while (p_cmd != i2cbb_pkg::CMD_IDLE)
      send_tick(tick_item(i2cbb_pkg::OP_NONE, 8'($urandom), 1'($urandom), SDA_RANDOM));
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] ticks);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    p_len = ticks;
  endtask

  // Idle ticks straight after reset, unused opcode while idle
  task automatic test_reset_state();
    run_cmd(i2cbb_pkg::OP_NONE, 8'h00, 1'b0, SDA_LOW, 0);
    run_cmd(i2cbb_pkg::OP_NONE, 8'hFF, 1'b1, SDA_HIGH, 0);
    run_cmd(OP_UNUSED, 8'hA5, 1'b1, SDA_RANDOM, 0);
    run_cmd(OP_UNUSED, 8'h5A, 1'b0, SDA_RANDOM, 0);
  endtask

  // Every command at least once, with extreme bytes and levels
  task automatic test_each_command();
    run_cmd(i2cbb_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_SEND, 8'hFF, 1'b0, SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_RECV_ACK, 8'h00, 1'b0, SDA_LOW, 0);
    run_cmd(i2cbb_pkg::OP_SEND, 8'h00, 1'b1, SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_RECV_ACK, 8'h00, 1'b0, SDA_HIGH, 0);
    run_cmd(i2cbb_pkg::OP_RECV, 8'h00, 1'b0, SDA_HIGH, 0);
    run_cmd(i2cbb_pkg::OP_SEND_ACK, 8'hFF, 1'b0, SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_RECV, 8'hFF, 1'b1, SDA_LOW, 0);
    run_cmd(i2cbb_pkg::OP_SEND_ACK, 8'h00, 1'b1, SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_RECV, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
  endtask

  // Stray opcodes on every busy tick, the done tick included
  task automatic test_busy_reject();
    run_cmd(i2cbb_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM, 100);
    write_step(16'd2);
    run_cmd(i2cbb_pkg::OP_RECV_ACK, 8'h00, 1'b0, SDA_RANDOM, 100);
    run_cmd(i2cbb_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 100);
  endtask

  // A step length of zero holds each step for one tick
  task automatic test_zero_step();
    write_step(16'd0);
    run_cmd(i2cbb_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_SEND, 8'($urandom), 1'b0, SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_SEND_ACK, 8'h00, 1'($urandom), SDA_RANDOM, 0);
    run_cmd(i2cbb_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
  endtask

  // Step length past eight bits on a short command
  task automatic test_long_step();
    write_step(16'd257);
    run_cmd(i2cbb_pkg::OP_SEND_ACK, 8'h00, 1'($urandom), SDA_RANDOM, 3);
  endtask

  // Mostly well-formed transactions, some broken ones and stray beats
  task automatic test_random_transactions();
    int txns;
    int pick;
    while (beats_sent < RANDOM_END) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      write_step(16'd0);
      else if (pick <= 5) write_step(16'd1);
      else if (pick <= 8) write_step(16'($urandom_range(2, 4)));
      else                write_step(16'($urandom_range(5, 8)));
      txns = $urandom_range(2, 5);
      repeat (txns) begin
        if (beats_sent < RANDOM_END) begin
          if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4))
              run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), SDA_RANDOM, 20);
          end else begin
            run_cmd(i2cbb_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
            run_cmd(i2cbb_pkg::OP_SEND, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
            run_cmd(i2cbb_pkg::OP_RECV_ACK, 8'($urandom), 1'($urandom),
                    ($urandom_range(0, 3) == 0) ? SDA_RANDOM : SDA_LOW, 5);
            repeat ($urandom_range(0, 3)) begin
              if ($urandom_range(0, 1) == 0) begin
                run_cmd(i2cbb_pkg::OP_SEND, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
                run_cmd(i2cbb_pkg::OP_RECV_ACK, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
              end else begin
                run_cmd(i2cbb_pkg::OP_RECV, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
                run_cmd(i2cbb_pkg::OP_SEND_ACK, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
              end
            end
            // drop the stop now and then to leave a broken transaction
            if ($urandom_range(0, 7) != 0)
              run_cmd(i2cbb_pkg::OP_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
          end
          repeat ($urandom_range(0, 3))
            run_cmd(i2cbb_pkg::OP_NONE, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
        end
      end
    end
  endtask

  // Largest step length: run the first step part way only
  task automatic test_max_step();
    logic [2:0] op;
    write_step(16'hFFFF);
    send_tick(tick_item(i2cbb_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM));
    repeat (150) begin
      op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : i2cbb_pkg::OP_NONE;
      send_tick(tick_item(op, 8'($urandom), 1'($urandom), SDA_RANDOM));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_each_command();
    test_busy_reject();
    test_zero_step();
    test_long_step();
    test_random_transactions();
    test_max_step();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop if results never drain
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### i2c_bitbang_master_engine_top.f
+incdir+rtl
rtl/i2cbb_pkg.sv
rtl/i2cbb_step_dec.sv
rtl/i2cbb_core.sv
rtl/i2cbb_out_reg.sv
rtl/i2c_bitbang_master_engine_top.sv
tb/sv/testbench.sv
